// ----- hw/rtl/gwtd_pkg.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// gwtd_pkg
// Shared constants for the grid wait-time search block.
// -----------------------------------------------------------------------------
package gwtd_pkg;
  localparam int unsigned TimeW = 30;
  localparam int unsigned DistW = 31;
  localparam int unsigned CfgW  = 7;
  localparam logic [DistW-1:0] DistInf = {DistW{1'b1}};
  localparam logic [0:0] RegRows = 1'b0;
  localparam logic [0:0] RegCols = 1'b1;
endpackage
`default_nettype wire

// ----- hw/rtl/gwtd_if.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// gwtd_if
// Valid/ready channels: cell input, result output and configuration writes.
// -----------------------------------------------------------------------------
interface gwtd_in_if;
  logic        valid;
  logic        ready;
  logic [29:0] move_time;
  logic        last_cell;
  modport source (output valid, move_time, last_cell, input ready);
  modport sink   (input valid, move_time, last_cell, output ready);
endinterface

interface gwtd_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] min_time;
  modport source (output valid, min_time, input ready);
  modport sink   (input valid, min_time, output ready);
endinterface

interface gwtd_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [6:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/grid_wait_time_dijkstra_core.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// grid_wait_time_dijkstra_core
// Earliest-arrival search over a loaded grid with a binary min-heap in RAM.
// -----------------------------------------------------------------------------
// Cells arrive on in_if one item per cycle while loading, in row-major order; configuration
// writes on cfg_if set rows (index 0) and cols (index 1) and are accepted only
// while cells are loading. Items past rows*cols are not stored. An item with
// last_cell set starts the search; no further item is accepted until it ends.
// The search first clears distance and visited bits, one cell per cycle, over
// all MAX_ROWS*MAX_COLS cells. A heap pop reads the root and the last entry,
// moves the last entry to the root and sifts it down. A visit skips a visited
// cell, else sets its visited bit and splits the cell index into row and column.
// A relaxation reads the neighbour's distance and, if the candidate is smaller
// and the heap has room, writes it, pushes the entry and sifts it up. The final distance is then read.
// Grid, distance, visited and heap data lie in single-port RAMs with registered
// read data; the sequencer touches one entry per RAM at a time, so none overlap.
// Reset clears the control state; the grid store is undefined until loaded.
// A stalled receiver leaves the result in its output register while the next
// grid loads; a search that ends before that result is taken holds its own.
// -----------------------------------------------------------------------------
module grid_wait_time_dijkstra_core import gwtd_pkg::*; #(
  parameter int unsigned MAX_ROWS   = 64,
  parameter int unsigned MAX_COLS   = 64,
  parameter int unsigned HEAP_DEPTH = 16384
) (
  input wire clk_i,
  input wire rst_ni,
  gwtd_in_if.sink    in_if,
  gwtd_out_if.source out_if,
  gwtd_cfg_if.sink   cfg_if
);
  localparam int unsigned Cells = MAX_ROWS * MAX_COLS;
  localparam int unsigned CellW = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int unsigned HeapW = $clog2(HEAP_DEPTH);
  localparam int unsigned CntW  = HeapW + 1;
  localparam int unsigned RW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned CW    = $clog2(MAX_COLS + 1);
  localparam int unsigned EntW  = CellW + DistW;
  localparam int unsigned DvW   = $clog2(CellW + 1);

  typedef enum logic [17:0] {
    StLoad   = 18'h00001, StClear  = 18'h00002, StPop    = 18'h00004,
    StPopRd  = 18'h00008, StPopUse = 18'h00010, StSdRdL  = 18'h00020,
    StSdRdR  = 18'h00040, StSdCmp  = 18'h00080, StSdWr   = 18'h00100,
    StVisit  = 18'h00200, StNb     = 18'h00400, StNbRd   = 18'h00800,
    StNbCmp  = 18'h01000, StPush   = 18'h02000, StSuRd   = 18'h04000,
    StSuCmp  = 18'h08000, StFinRd  = 18'h10000, StDiv    = 18'h20000
  } state_e;

  state_e state_q, state_d;
  logic [CfgW-1:0] rows_q, cols_q;
  logic [RW-1:0] nr;
  logic [CW-1:0] nc;
  logic [CellW:0] load_q, total;
  logic [CellW:0] clr_q;
  logic [CntW-1:0] cnt_q;
  logic [EntW-1:0] cur_q, tmp_q, lft_q;
  logic [HeapW-1:0] idx_q, kid_q;
  logic [1:0] dir_q, sub_q;
  logic [RW-1:0] r_q;
  logic [CW-1:0] c_q;
  logic [CellW-1:0] nb_q;
  logic [DistW-1:0] cand_q, res_q;
  logic out_valid_q;
  logic [TimeW-1:0] et_rd;
  logic [DistW-1:0] bd_rd;
  logic [0:0] vs_rd;
  logic [EntW-1:0] hp_rd;
  logic [CellW-1:0] dv_num_q, dv_quo_q, dv_quo_d;
  logic [CW-1:0] dv_rem_q, dv_rem_d;
  logic [DvW-1:0] dv_cnt_q;
  logic [CW:0] dv_trial;
  logic dv_ge;

  logic et_we, bd_we, vs_we, hp_we;
  logic [CellW-1:0] et_a, bd_a, vs_a;
  logic [HeapW-1:0] hp_a;
  logic [DistW-1:0] bd_wd;
  logic vs_wd;
  logic [EntW-1:0] hp_wd;

  gwtd_ram #(.Width(TimeW), .Depth(Cells)) u_et (
    .clk_i, .we_i(et_we), .addr_i(et_a), .wdata_i(in_if.move_time), .rdata_o(et_rd));
  gwtd_ram #(.Width(DistW), .Depth(Cells)) u_bd (
    .clk_i, .we_i(bd_we), .addr_i(bd_a), .wdata_i(bd_wd), .rdata_o(bd_rd));
  gwtd_ram #(.Width(1), .Depth(Cells)) u_vs (
    .clk_i, .we_i(vs_we), .addr_i(vs_a), .wdata_i(vs_wd), .rdata_o(vs_rd));
  gwtd_ram #(.Width(EntW), .Depth(HEAP_DEPTH)) u_hp (
    .clk_i, .we_i(hp_we), .addr_i(hp_a), .wdata_i(hp_wd), .rdata_o(hp_rd));

  always_comb begin
    nr = (rows_q == '0) ? RW'(1) : (32'(rows_q) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(rows_q);
    nc = (cols_q == '0) ? CW'(1) : (32'(cols_q) > MAX_COLS) ? CW'(MAX_COLS) : CW'(cols_q);
    total = (CellW+1)'(32'(nr) * 32'(nc));
  end

  // Restoring division of the cell index by the column count, one bit a cycle.
  always_comb begin
    dv_trial = {dv_rem_q, dv_num_q[CellW-1]};
    dv_ge = (dv_trial >= (CW+1)'(nc));
    dv_rem_d = dv_ge ? CW'(dv_trial - (CW+1)'(nc)) : CW'(dv_trial);
    dv_quo_d = (dv_quo_q << 1) | CellW'(dv_ge);
  end

  function automatic logic [DistW-1:0] tm(input logic [EntW-1:0] e);
    return e[DistW-1:0];
  endfunction

  wire in_acc  = in_if.valid && in_if.ready;
  wire cfg_acc = cfg_if.valid && cfg_if.ready;
  assign in_if.ready   = (state_q == StLoad);
  assign cfg_if.ready  = (state_q == StLoad);
  assign out_if.valid  = out_valid_q;
  assign out_if.min_time = res_q;

  // Neighbor geometry for the current direction.
  logic nb_ok;
  logic [CellW-1:0] nb_cell;
  logic [CellW-1:0] cur_cell;
  logic [DistW-1:0] mx;
  always_comb begin
    cur_cell = cur_q[EntW-1:DistW];
    nb_ok = 1'b0;
    nb_cell = cur_cell;
    unique case (dir_q)
      2'd0: begin nb_ok = (r_q != '0); nb_cell = cur_cell - CellW'(nc); end
      2'd1: begin nb_ok = (c_q != '0); nb_cell = cur_cell - CellW'(1); end
      2'd2: begin nb_ok = (32'(c_q) + 1 < 32'(nc)); nb_cell = cur_cell + CellW'(1); end
      default: begin nb_ok = (32'(r_q) + 1 < 32'(nr)); nb_cell = cur_cell + CellW'(nc); end
    endcase
    mx = (tm(cur_q) > DistW'(et_rd)) ? tm(cur_q) : DistW'(et_rd);
  end

  wire [HeapW:0] lkid = {idx_q, 1'b1};
  wire [HeapW:0] rkid = {idx_q, 1'b0} + (HeapW+1)'(2);
  wire [HeapW-1:0] par = HeapW'((idx_q - HeapW'(1)) >> 1);

  always_comb begin
    state_d = state_q;
    et_we = 1'b0; et_a = load_q[CellW-1:0];
    bd_we = 1'b0; bd_a = clr_q[CellW-1:0]; bd_wd = DistInf;
    vs_we = 1'b0; vs_a = clr_q[CellW-1:0]; vs_wd = 1'b0;
    hp_we = 1'b0; hp_a = idx_q; hp_wd = tmp_q;
    unique case (state_q)
      StLoad: begin
        et_we = in_acc && (load_q < total);
        if (in_acc && in_if.last_cell) state_d = StClear;
      end
      StClear: begin
        bd_we = 1'b1; vs_we = 1'b1;
        bd_wd = (clr_q == '0) ? '0 : DistInf;
        if (32'(clr_q) == Cells - 1) state_d = StPush;
      end
      StPop: begin
        hp_a = '0;
        if (cnt_q == '0) state_d = StFinRd;
        else state_d = StPopRd;
      end
      StPopRd: begin
        hp_a = HeapW'(cnt_q - CntW'(1));
        state_d = StPopUse;
      end
      StPopUse: begin
        hp_a = '0; hp_we = 1'b1; hp_wd = hp_rd;
        state_d = StSdRdL;
      end
      StSdRdL: begin
        hp_a = lkid[HeapW-1:0];
        if (CntW'(lkid) >= cnt_q || lkid[HeapW]) begin
          hp_a = idx_q; hp_we = 1'b1; hp_wd = tmp_q;
          state_d = StVisit;
        end else state_d = StSdRdR;
      end
      StSdRdR: begin
        hp_a = rkid[HeapW-1:0];
        state_d = StSdCmp;
      end
      StSdCmp: state_d = StSdWr;
      StSdWr: begin
        hp_we = 1'b1;
        hp_a = idx_q; hp_wd = (kid_q != idx_q) ? lft_q : tmp_q;
        state_d = (kid_q != idx_q) ? StSdRdL : StVisit;
      end
      StVisit: begin
        vs_a = cur_cell;
        if (sub_q == 2'd1) begin
          if (32'(cur_cell) >= Cells || vs_rd[0]) state_d = StPop;
          else begin vs_we = 1'b1; vs_wd = 1'b1; state_d = StDiv; end
        end
      end
      StDiv: if (dv_cnt_q == DvW'(CellW - 1)) state_d = StNb;
      StNb: begin
        et_a = nb_cell; bd_a = nb_cell;
        if (sub_q == '0) begin
          if (nb_ok) state_d = StNbRd;
          else if (dir_q == 2'd3) state_d = StPop;
        end
      end
      StNbRd: begin
        bd_a = nb_q;
        state_d = StNbCmp;
      end
      StNbCmp: begin
        bd_a = nb_q;
        if (cand_q < bd_rd && 32'(cnt_q) < HEAP_DEPTH) begin
          bd_we = 1'b1; bd_wd = cand_q; state_d = StPush;
        end else state_d = (dir_q == 2'd3) ? StPop : StNb;
      end
      StPush: begin
        hp_a = HeapW'(cnt_q); hp_we = 1'b1; hp_wd = tmp_q;
        state_d = StSuRd;
      end
      StSuRd: begin
        hp_a = (idx_q == '0) ? idx_q : par;
        hp_we = (idx_q == '0);
        state_d = (idx_q == '0) ? ((cur_q == '1) ? StPop : ((dir_q == 2'd3) ? StPop : StNb))
                                : StSuCmp;
      end
      StSuCmp: begin
        if (tm(tmp_q) < tm(hp_rd)) begin
          hp_a = idx_q; hp_we = 1'b1; hp_wd = hp_rd;
          state_d = StSuRd;
        end else begin
          hp_a = idx_q; hp_we = 1'b1; hp_wd = tmp_q;
          state_d = (cur_q == '1 || dir_q == 2'd3) ? StPop : StNb;
        end
      end
      StFinRd: begin
        bd_a = CellW'(total - (CellW+1)'(1));
        if (sub_q != 2'd0 && (!out_valid_q || out_if.ready)) state_d = StLoad;
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      rows_q <= CfgW'(1); cols_q <= CfgW'(1);
      load_q <= '0; clr_q <= '0; cnt_q <= '0;
      idx_q <= '0; kid_q <= '0; dir_q <= '0; sub_q <= '0;
      nb_q <= '0; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_acc) begin
        if (cfg_if.index == RegRows) rows_q <= cfg_if.data;
        if (cfg_if.index == RegCols) cols_q <= cfg_if.data;
      end
      if (state_q == StFinRd && state_d == StLoad) out_valid_q <= 1'b1;
      else if (out_valid_q && out_if.ready) out_valid_q <= 1'b0;
      sub_q <= (state_d != state_q) ? 2'd0 : sub_q + 2'd1;
      unique case (state_q)
        StLoad: begin
          if (in_acc && load_q < total) load_q <= load_q + 1'b1;
          if (in_acc && in_if.last_cell) clr_q <= '0;
        end
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (state_d == StPush) begin
            cnt_q <= '0; idx_q <= '0; load_q <= '0;
          end
        end
        StPopRd: cnt_q <= cnt_q - CntW'(1);
        StPopUse: idx_q <= '0;
        StSdRdL: kid_q <= idx_q;
        StSdCmp: begin
          kid_q <= idx_q;
          if (tm(lft_q) < tm(tmp_q)) kid_q <= lkid[HeapW-1:0];
          if (CntW'(rkid) < cnt_q && !rkid[HeapW]) begin
            if (tm(hp_rd) < ((tm(lft_q) < tm(tmp_q)) ? tm(lft_q) : tm(tmp_q)))
              kid_q <= rkid[HeapW-1:0];
          end
        end
        StSdWr: idx_q <= kid_q;
        StVisit: if (state_d == StDiv) dir_q <= '0;
        StNb: if (sub_q == '0) begin
          nb_q <= nb_cell;
          if (!nb_ok) dir_q <= dir_q + 2'd1;
        end
        StNbCmp: if (state_d != StPush) dir_q <= dir_q + 2'd1;
        StPush: begin idx_q <= HeapW'(cnt_q); cnt_q <= cnt_q + CntW'(1); end
        StSuCmp: if (state_d == StSuRd) idx_q <= par;
                 else if (cur_q != '1) dir_q <= dir_q + 2'd1;
        StFinRd: ;
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StClear: if (state_d == StPush) begin
        tmp_q <= '0; cur_q <= '1;
      end
      StPopRd: cur_q <= hp_rd;
      StPopUse: tmp_q <= hp_rd;
      StSdRdL: if (state_d == StSdRdR) lft_q <= hp_rd;
      StSdRdR: lft_q <= hp_rd;
      StSdCmp: begin
        // lft_q now carries the chosen child entry.
        if (CntW'(rkid) < cnt_q && !rkid[HeapW] &&
            tm(hp_rd) < ((tm(lft_q) < tm(tmp_q)) ? tm(lft_q) : tm(tmp_q)))
          lft_q <= hp_rd;
      end
      StSdWr: if (kid_q != idx_q) lft_q <= lft_q;
      StVisit: begin
        dv_num_q <= cur_cell;
        dv_rem_q <= '0;
        dv_quo_q <= '0;
        dv_cnt_q <= '0;
      end
      StDiv: begin
        dv_num_q <= dv_num_q << 1;
        dv_rem_q <= dv_rem_d;
        dv_quo_q <= dv_quo_d;
        dv_cnt_q <= dv_cnt_q + DvW'(1);
        r_q <= RW'(dv_quo_d);
        c_q <= dv_rem_d;
      end
      StNbRd: cand_q <= (mx == DistInf) ? DistInf : mx + DistW'(1);
      StNbCmp: tmp_q <= {nb_q, cand_q};
      StFinRd: if (state_d == StLoad) res_q <= (total == (CellW+1)'(1)) ? '0 : bd_rd;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- hw/rtl/gwtd_ram.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// gwtd_ram
// Single-port synchronous RAM with registered read data.
// -----------------------------------------------------------------------------
module gwtd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] addr_i,
  input  wire [Width-1:0]         wdata_i,
  output logic [Width-1:0]        rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ----- tb/sv/tb_grid_wait_time_dijkstra_core.sv -----
// -----------------------------------------------------------------------------
// tb_grid_wait_time_dijkstra_core
// Self-checking testbench for the grid earliest-arrival search block.
// -----------------------------------------------------------------------------
// Grids of entry times are loaded cell by cell under several row and column
// settings. A behavioral shortest-path predictor computes the arrival time at
// the bottom-right cell for every item that ends a grid. Results are compared
// in order, under random sender gaps, receiver stalls and one long hold-off.
// -----------------------------------------------------------------------------
module tb_grid_wait_time_dijkstra_core import gwtd_pkg::*; ;

  localparam int Cells = 64 * 64;
  localparam int IdleLimit = 100000;
  localparam longint DistAllOnes = 64'h7FFF_FFFF;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  logic clk;
  logic rst_n;

  gwtd_in_if  cell_ch ();
  gwtd_out_if time_ch ();
  gwtd_cfg_if cfg_ch ();

  grid_wait_time_dijkstra_core uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_if (cell_ch),
    .out_if(time_ch),
    .cfg_if(cfg_ch)
  );

  logic [TimeW-1:0] entry_times[Cells];
  bit               entry_loaded[Cells];
  longint           best_dist[Cells];
  bit               settled[Cells];
  logic [CfgW-1:0]  rows_reg;
  logic [CfgW-1:0]  cols_reg;
  int               load_pos;
  logic [DistW-1:0] arrival_q[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int cells_sent;
  int grids_done;
  int mismatches;
  int failures;
  int idle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int clamp_dim(logic [CfgW-1:0] v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return int'(v);
  endfunction

  function automatic logic [DistW-1:0] search_grid(int nr, int nc);
    int n;
    int u;
    int r;
    int c;
    int rr;
    int cc;
    int nb;
    longint cand;
    n = nr * nc;
    for (int k = 0; k < n; k++) begin
      best_dist[k] = DistAllOnes;
      settled[k] = 1'b0;
    end
    best_dist[0] = 0;
    for (int step = 0; step < n; step++) begin
      u = -1;
      for (int k = 0; k < n; k++) begin
        if (!settled[k] && best_dist[k] < DistAllOnes &&
            (u < 0 || best_dist[k] < best_dist[u])) u = k;
      end
      if (u < 0) break;
      settled[u] = 1'b1;
      r = u / nc;
      c = u % nc;
      for (int d = 0; d < 4; d++) begin
        rr = r + ((d == 0) ? -1 : (d == 3) ? 1 : 0);
        cc = c + ((d == 1) ? -1 : (d == 2) ? 1 : 0);
        if (rr < 0 || cc < 0 || rr >= nr || cc >= nc) continue;
        nb = rr * nc + cc;
        cand = longint'(entry_times[nb]);
        if (best_dist[u] > cand) cand = best_dist[u];
        cand = cand + 1;
        if (cand > DistAllOnes) cand = DistAllOnes;
        if (cand < best_dist[nb]) best_dist[nb] = cand;
      end
    end
    return best_dist[n - 1][DistW-1:0];
  endfunction

  function automatic void predict_cell(logic [TimeW-1:0] t, logic last);
    int nr;
    int nc;
    nr = clamp_dim(rows_reg);
    nc = clamp_dim(cols_reg);
    if (load_pos < nr * nc) begin
      entry_times[load_pos] = t;
      entry_loaded[load_pos] = 1'b1;
      load_pos++;
    end
    if (last) begin
      arrival_q.push_back(search_grid(nr, nc));
      load_pos = 0;
    end
  endfunction

  task automatic send_cell(logic [TimeW-1:0] t, logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      cell_ch.valid = 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    cell_ch.valid = 1'b1;
    cell_ch.move_time = t;
    cell_ch.last_cell = last;
    @(posedge clk);
    while (!cell_ch.ready) @(posedge clk);
    predict_cell(t, last);
    cells_sent++;
    @(negedge clk);
    cell_ch.valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (arrival_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == RegRows) rows_reg = val;
    else cols_reg = val;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_dims(logic [CfgW-1:0] r, logic [CfgW-1:0] c);
    wait_idle();
    write_reg(RegRows, r);
    write_reg(RegCols, c);
  endtask

  function automatic logic [TimeW-1:0] pick_time(int mode);
    case (mode)
      0: return TimeW'($urandom_range(12));
      1: return TimeW'($urandom_range(200));
      2: return TimeW'($urandom) & TimeMax;
      default: return ($urandom_range(1)) ? TimeMax : '0;
    endcase
  endfunction

  // Loads one grid. A positive early_at below the grid size ends the load after that many cells,
  // which is only done when every later cell of the grid already holds a value.
  task automatic load_grid(int early_at, int surplus, int mode);
    int total;
    int stop_at;
    total = clamp_dim(rows_reg) * clamp_dim(cols_reg);
    stop_at = total;
    if (early_at > 0 && early_at < total) begin
      stop_at = early_at;
      for (int k = early_at; k < total; k++) if (!entry_loaded[k]) stop_at = total;
    end
    if (stop_at < total) begin
      for (int k = 0; k < stop_at; k++) send_cell(pick_time(mode), k == stop_at - 1);
    end else begin
      for (int k = 0; k < total + surplus; k++) begin
        send_cell(pick_time(mode), k == total + surplus - 1);
      end
    end
    grids_done++;
  endtask

  task automatic test_directed();
    set_dims(1, 1);
    send_cell(TimeMax, 1'b1);
    send_cell('0, 1'b1);
    set_dims(2, 2);
    for (int k = 0; k < 4; k++) send_cell(TimeMax, k == 3);
    for (int k = 0; k < 4; k++) send_cell(TimeW'(k * 5), k == 3);
    set_dims(3, 3);
    load_grid(0, 0, 1);
    load_grid(4, 0, 2);
    load_grid(0, 3, 0);
    set_dims(0, 2);
    load_grid(0, 0, 3);
  endtask

  task automatic test_config_extremes();
    set_dims(127, 0);
    load_grid(0, 2, 2);
    set_dims(64, 1);
    load_grid(0, 0, 1);
    set_dims(1, 64);
    load_grid(0, 0, 3);
    set_dims(0, 127);
    load_grid(30, 0, 0);
    set_dims(8, 8);
    load_grid(0, 0, 2);
  endtask

  task automatic test_random(int idle_pct, int stall_pct, int n_items);
    int target;
    int kind;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    target = cells_sent + n_items;
    while (cells_sent < target) begin
      kind = $urandom_range(99);
      if (kind < 5) set_dims(CfgW'($urandom_range(127, 65)), CfgW'($urandom_range(1)));
      else if (kind < 8) set_dims(0, CfgW'($urandom_range(6)));
      else if (kind < 15) set_dims(CfgW'($urandom_range(16, 1)), CfgW'($urandom_range(4, 1)));
      else set_dims(CfgW'($urandom_range(7, 1)), CfgW'($urandom_range(7, 1)));
      kind = $urandom_range(99);
      if (kind < 80) load_grid(0, 0, $urandom_range(3));
      else if (kind < 90) load_grid($urandom_range(20, 1), 0, $urandom_range(3));
      else load_grid(0, $urandom_range(5, 1), $urandom_range(3));
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_dims(2, 3);
    hold_cycles = 12000;
    for (int g = 0; g < 4; g++) load_grid(0, 0, 1);
  endtask

  initial begin
    rst_n = 1'b0;
    cell_ch.valid = 1'b0;
    cell_ch.move_time = '0;
    cell_ch.last_cell = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = RegRows;
    cfg_ch.data = '0;
    time_ch.ready = 1'b0;
    rows_reg = 1;
    cols_reg = 1;
    load_pos = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    cells_sent = 0;
    grids_done = 0;
    mismatches = 0;
    failures = 0;
    for (int k = 0; k < Cells; k++) entry_loaded[k] = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_config_extremes();
    test_random(0, 0, 380);
    test_random(72, 0, 340);
    test_random(0, 72, 340);
    test_random(33, 33, 340);
    test_backpressure();

    while (arrival_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (arrival_q.size() > 0) failures++;
    $display("Covered %0d cells in %0d grids, including clamped sizes and early ends.",
             cells_sent, grids_done);
    $display("Mismatches: %0d, other failures: %0d.", mismatches, failures);
    if (mismatches == 0 && failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      time_ch.ready = 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      time_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && time_ch.valid && time_ch.ready) begin
      if (arrival_q.size() == 0) begin
        failures++;
        $display("Result %0d arrived with no grid pending.", time_ch.min_time);
      end else begin
        if (time_ch.min_time !== arrival_q[0]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("min_time mismatch: expected %0d, got %0d", arrival_q[0],
                     time_ch.min_time);
          end
        end
        void'(arrival_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((cell_ch.valid && cell_ch.ready) || (time_ch.valid && time_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      idle_count <= 0;
    end else if (idle_count >= IdleLimit) begin
      $display("Timeout with %0d results outstanding.", arrival_q.size());
      $display("Some tests failed");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end
endmodule

// ----- filelist.f -----
hw/rtl/gwtd_pkg.sv
hw/rtl/gwtd_if.sv
hw/rtl/gwtd_ram.sv
hw/rtl/grid_wait_time_dijkstra_core.sv
tb/sv/tb_grid_wait_time_dijkstra_core.sv
